// ----- rtl/core/cfwdp_pkg.sv -----
// ----------------------------------------------------------------------------
// cfwdp_pkg: shared types and constants of the complex FIR window dot product
// Field types, command codes and the structs passed between the cell row,
// the multiply-accumulate lanes and the sequencer.
// ----------------------------------------------------------------------------
package cfwdp_pkg;

  typedef logic [1:0]         cmd_t;
  typedef logic signed [7:0]  sample_t;
  typedef logic [5:0]         tap_idx_t;
  typedef logic signed [15:0] tap_t;
  typedef logic signed [15:0] result_t;

  // Command codes
  localparam cmd_t CMD_PUSH    = 2'd0;
  localparam cmd_t CMD_TAP     = 2'd1;
  localparam cmd_t CMD_COMPUTE = 2'd2;

  // 8 x 16 signed product; the sum of (sample << 8) * tap wraps at 32 bits,
  // so only the low 24 bits of the plain product sum matter.
  localparam int PROD_W = 24;
  localparam int ACC_W  = 24;
  // Result is bits 31:16 of the shifted sum, i.e. bits 23:8 of the plain sum
  localparam int RES_LSB = 8;

  // Contents of one delay-line cell
  typedef struct packed {
    sample_t i;
    sample_t q;
    tap_t    tap;
  } cell_data_t;

  // Row control shared by every cell
  typedef struct packed {
    logic push;    // shift samples one cell towards the oldest end
    logic rotate;  // rotate samples and taps by one lane group
  } cell_ctl_t;

  // Lane control from the sequencer
  typedef struct packed {
    logic clear;       // zero the accumulators
    logic capture;     // register the lane products
    logic accumulate;  // add the registered products
  } mac_ctl_t;

endpackage

// ----- rtl/core/cfwdp_in_if.sv -----
// ----------------------------------------------------------------------------
// cfwdp_in_if: command channel
// Valid/ready channel carrying one command item with its sample and tap fields.
// ----------------------------------------------------------------------------
interface cfwdp_in_if;
  logic                 valid;
  logic                 ready;
  cfwdp_pkg::cmd_t      command;
  cfwdp_pkg::sample_t   sample_i;
  cfwdp_pkg::sample_t   sample_q;
  cfwdp_pkg::tap_idx_t  tap_index;
  cfwdp_pkg::tap_t      tap_value;

  modport source (
    output valid, command, sample_i, sample_q, tap_index, tap_value,
    input  ready
  );
  modport sink (
    input  valid, command, sample_i, sample_q, tap_index, tap_value,
    output ready
  );
endinterface

// ----- rtl/core/cfwdp_out_if.sv -----
// ----------------------------------------------------------------------------
// cfwdp_out_if: result channel
// Valid/ready channel carrying one I/Q dot product result item.
// ----------------------------------------------------------------------------
interface cfwdp_out_if;
  logic                valid;
  logic                ready;
  cfwdp_pkg::result_t  result_i;
  cfwdp_pkg::result_t  result_q;

  modport source (output valid, result_i, result_q, input ready);
  modport sink   (input  valid, result_i, result_q, output ready);
endinterface

// ----- rtl/core/complex_fir_window_dot_product.sv -----
// ----------------------------------------------------------------------------
// complex_fir_window_dot_product: FIR window over complex samples, real taps
// Row of TAPS cells holding the sample window and taps, lane MAC and
// sequencer with a one-item result register.
// ----------------------------------------------------------------------------
// Pushes and tap writes are taken while the sequencer is idle. A compute
// holds off the next item until its result is loaded: the cell row rotates
// by LANES cells a cycle past the LANES multiply-accumulate lanes through
// the TAPS/LANES rotation steps (S_RUN), then the last products are folded
// in (S_LAST) and the result register is loaded (S_DONE). A finished result
// waits in that register while further pushes and tap writes are taken; a
// compute that finishes while it is still full waits until it drains. TAPS
// must be a multiple of LANES. The sample window shifts physically, so
// outside a compute cell 0 holds the oldest sample and pairs with tap 0.
// ----------------------------------------------------------------------------
module complex_fir_window_dot_product #(
  parameter int TAPS  = 64,
  parameter int LANES = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  cfwdp_in_if.sink         in_ch,
  cfwdp_out_if.source      out_ch
);

  localparam int GROUPS = TAPS / LANES;
  localparam int CNT_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_LAST = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             prod_v_r;
  logic             out_valid_r, out_valid_nxt;
  cfwdp_pkg::result_t out_i_r, out_q_r;

  logic accept, do_push, do_tap, do_compute, out_load;

  cfwdp_pkg::cell_ctl_t  cell_ctl;
  cfwdp_pkg::mac_ctl_t   mac_ctl;
  cfwdp_pkg::cell_data_t cell_q    [TAPS];
  cfwdp_pkg::cell_data_t lane_data [LANES];
  cfwdp_pkg::cell_data_t new_sample;
  logic [cfwdp_pkg::ACC_W-1:0] acc_i, acc_q;

  // Decode the accepted command
  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign do_push     = accept && (in_ch.command == cfwdp_pkg::CMD_PUSH);
  assign do_tap      = accept && (in_ch.command == cfwdp_pkg::CMD_TAP);
  assign do_compute  = accept && (in_ch.command == cfwdp_pkg::CMD_COMPUTE);

  // Load the result once the output slot is free
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  assign cell_ctl.push   = do_push;
  assign cell_ctl.rotate = (state_r == S_RUN);

  assign mac_ctl.clear      = do_compute;
  assign mac_ctl.capture    = (state_r == S_RUN);
  assign mac_ctl.accumulate = prod_v_r;

  assign new_sample.i   = in_ch.sample_i;
  assign new_sample.q   = in_ch.sample_q;
  assign new_sample.tap = '0;

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (do_compute) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (cnt_r == CNT_W'(GROUPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_LAST;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_LAST: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output slot occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.valid && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      prod_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      prod_v_r    <= (state_r == S_RUN);
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_i_r <= acc_i[cfwdp_pkg::RES_LSB +: 16];
      out_q_r <= acc_q[cfwdp_pkg::RES_LSB +: 16];
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.result_i = out_i_r;
  assign out_ch.result_q = out_q_r;

  // Row of cells: push enters at the newest end, rotate wraps by one group
  for (genvar j = 0; j < TAPS; j++) begin : g_cell
    cfwdp_pkg::cell_data_t shift_src;
    logic                  tap_wr;

    if (j == TAPS - 1) begin : g_top
      assign shift_src = new_sample;
    end else begin : g_mid
      assign shift_src = cell_q[j + 1];
    end

    assign tap_wr = do_tap && (32'(in_ch.tap_index) == j);

    cfwdp_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (cell_ctl),
      .tap_wr    (tap_wr),
      .tap_value (in_ch.tap_value),
      .shift_in  (shift_src),
      .rot_in    (cell_q[(j + LANES) % TAPS]),
      .data      (cell_q[j])
    );
  end

  // Lanes read the lowest group of cells
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    assign lane_data[l] = cell_q[l];
  end

  cfwdp_mac #(
    .LANES (LANES)
  ) u_mac (
    .clk       (clk),
    .ctl       (mac_ctl),
    .lane_data (lane_data),
    .acc_i     (acc_i),
    .acc_q     (acc_q)
  );

`ifndef ASSERT_OFF
  // A compute reaches the result stage after the full rotation and final add
  a_compute_len: assert property (@(posedge clk) disable iff (!rst_n)
    do_compute |-> ##(GROUPS + 2) (state_r == S_DONE))
    else $error("compute did not reach result stage on time");

  // Products are folded in only while a compute is under way
  a_acc_window: assert property (@(posedge clk) disable iff (!rst_n)
    mac_ctl.accumulate |-> (state_r == S_RUN || state_r == S_LAST))
    else $error("accumulate outside a compute");

  // A finished result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_ch.ready) |=> (state_r == S_DONE))
    else $error("result stage left while output slot full");

  // Group counter is back at zero whenever the sequencer is idle
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (cnt_r == '0))
    else $error("group counter not cleared");
`endif

endmodule

// ----- rtl/core/cfwdp_cell.sv -----
// ----------------------------------------------------------------------------
// cfwdp_cell: one delay-line cell
// Holds one complex sample and its tap. Takes the sample of its newer
// neighbour on a push, the whole content of the cell one lane group up on a
// rotate, and a new tap on a tap write.
// ----------------------------------------------------------------------------
module cfwdp_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfwdp_pkg::cell_ctl_t   ctl,
  input  logic                   tap_wr,
  input  cfwdp_pkg::tap_t        tap_value,
  input  cfwdp_pkg::cell_data_t  shift_in,
  input  cfwdp_pkg::cell_data_t  rot_in,
  output cfwdp_pkg::cell_data_t  data
);

  cfwdp_pkg::cell_data_t data_r;
  cfwdp_pkg::cell_data_t data_nxt;

  // Select the next content
  always_comb begin
    data_nxt = data_r;
    if (ctl.rotate) begin
      data_nxt = rot_in;
    end else begin
      if (ctl.push) begin
        data_nxt.i = shift_in.i;
        data_nxt.q = shift_in.q;
      end
      if (tap_wr) begin
        data_nxt.tap = tap_value;
      end
    end
  end

  // Hold sample and tap; both reset to zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

  assign data = data_r;

endmodule

// ----- rtl/core/cfwdp_mac.sv -----
// ----------------------------------------------------------------------------
// cfwdp_mac: multiply-accumulate lanes
// One 8 x 16 multiplier per lane for I and for Q, a product register, and
// one adder row folding the lane products into the I and Q accumulators.
// ----------------------------------------------------------------------------
module cfwdp_mac #(
  parameter int LANES = 8
) (
  input  logic                   clk,
  input  cfwdp_pkg::mac_ctl_t    ctl,
  input  cfwdp_pkg::cell_data_t  lane_data [LANES],
  output logic [cfwdp_pkg::ACC_W-1:0] acc_i,
  output logic [cfwdp_pkg::ACC_W-1:0] acc_q
);

  logic signed [cfwdp_pkg::PROD_W-1:0] prod_i_r [LANES];
  logic signed [cfwdp_pkg::PROD_W-1:0] prod_q_r [LANES];
  logic [cfwdp_pkg::ACC_W-1:0] acc_i_r, acc_i_nxt;
  logic [cfwdp_pkg::ACC_W-1:0] acc_q_r, acc_q_nxt;

  // Register the lane products
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      for (int l = 0; l < LANES; l++) begin
        prod_i_r[l] <= cfwdp_pkg::PROD_W'(lane_data[l].i) *
                       cfwdp_pkg::PROD_W'(lane_data[l].tap);
        prod_q_r[l] <= cfwdp_pkg::PROD_W'(lane_data[l].q) *
                       cfwdp_pkg::PROD_W'(lane_data[l].tap);
      end
    end
  end

  // Fold the products into the running sums, wrapping
  always_comb begin
    acc_i_nxt = acc_i_r;
    acc_q_nxt = acc_q_r;
    for (int l = 0; l < LANES; l++) begin
      acc_i_nxt = acc_i_nxt + cfwdp_pkg::ACC_W'(prod_i_r[l]);
      acc_q_nxt = acc_q_nxt + cfwdp_pkg::ACC_W'(prod_q_r[l]);
    end
  end

  // Clear at the start of a compute, advance while products arrive
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_i_r <= '0;
      acc_q_r <= '0;
    end else if (ctl.accumulate) begin
      acc_i_r <= acc_i_nxt;
      acc_q_r <= acc_q_nxt;
    end
  end

  assign acc_i = acc_i_r;
  assign acc_q = acc_q_r;

endmodule
